/* sv/met_pkg.sv */
// Shared types and fixed-point constants for the Mandelbrot escape-time unit.
package met_pkg;

    // Grid and number format are fixed for this block (Q4.28, 1024 x 1024 grid).
    localparam int GRID      = 1024;
    localparam int FRAC_BITS = 28;
    localparam int GRID_LOG2 = $clog2(GRID);

    // c = (index - GRID/2) * 4 / GRID, which is a plain left shift for this grid.
    localparam int C_SHIFT   = FRAC_BITS + 2 - GRID_LOG2;

    localparam int IDX_W     = 10;
    localparam int ITER_W    = 16;
    localparam int XW        = 32;
    localparam int PW        = 2 * XW;
    localparam int SQ_W      = PW - FRAC_BITS;
    localparam int XY_W      = SQ_W + 1;
    localparam int MAG_W     = SQ_W + 1;

    localparam int          ADDR_W       = 3;
    localparam logic        REG_MAX_ITER = 1'b0;
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(10000);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic step;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_sts;

endpackage

/* sv/met_dp.sv */
// Datapath: point mapping, z = z^2 + c iteration registers and result register.
module met_dp
    import met_pkg::*;
(
    input  logic                 i_clk,
    input  logic [IDX_W-1:0]     i_row_index,
    input  logic [IDX_W-1:0]     i_col_index,
    input  logic [ITER_W-1:0]    i_max_iter,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_inside_res,
    output logic [ITER_W-1:0]    o_iterations
);

    localparam logic signed [MAG_W-1:0] MAG_LIMIT = MAG_W'(64'd4 << FRAC_BITS);

    logic signed [XW-1:0]   r_x, r_y, r_cre, r_cim;
    logic signed [SQ_W-1:0] r_xx, r_yy;
    logic signed [XY_W-1:0] r_xy2;
    logic [ITER_W-1:0]      r_iter;
    logic                   r_res_inside;
    logic [ITER_W-1:0]      r_res_iter;

    logic signed [XW-1:0]   w_row_c, w_col_c;
    logic signed [PW-1:0]   w_pxx, w_pyy, w_pxy;
    logic signed [MAG_W-1:0] w_mag;
    logic signed [XW-1:0]   w_xn, w_yn;
    logic                   w_escape;

    assign w_row_c = (signed'(XW'(i_row_index)) - signed'(XW'(GRID / 2))) <<< C_SHIFT;
    assign w_col_c = (signed'(XW'(i_col_index)) - signed'(XW'(GRID / 2))) <<< C_SHIFT;

    assign w_pxx = r_x * r_x;
    assign w_pyy = r_y * r_y;
    assign w_pxy = r_x * r_y;

    // Magnitude test runs on the registered, truncated squares.
    assign w_mag    = {r_xx[SQ_W-1], r_xx} + {r_yy[SQ_W-1], r_yy};
    assign w_escape = (w_mag > MAG_LIMIT);
    assign o_sts.done = w_escape || (r_iter >= i_max_iter);

    // A step only runs when |z|^2 <= 4, so the new values fit the state width.
    assign w_xn = r_xx[XW-1:0] - r_yy[XW-1:0] + r_cre;
    assign w_yn = r_xy2[XW-1:0] + r_cim;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= '0;
            r_y    <= '0;
            r_cre  <= w_row_c;
            r_cim  <= w_col_c;
            r_iter <= '0;
        end else if (i_cmd.step) begin
            r_x    <= w_xn;
            r_y    <= w_yn;
            r_iter <= r_iter + ITER_W'(1);
        end
        if (i_cmd.mul_en) begin
            r_xx  <= w_pxx[PW-1:FRAC_BITS];
            r_yy  <= w_pyy[PW-1:FRAC_BITS];
            r_xy2 <= w_pxy[PW-1:FRAC_BITS-1];
        end
        if (i_cmd.res_load) begin
            r_res_iter   <= r_iter;
            r_res_inside <= (r_iter == i_max_iter);
        end
    end

    assign o_inside_res = r_res_inside;
    assign o_iterations = r_res_iter;

endmodule

/* sv/met_ctrl.sv */
// Controller: sequences load, multiply and update steps and owns the output beat flag.
module met_ctrl
    import met_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_cmd.load     = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mul_en   = (r_state == ST_MUL);
        o_cmd.step     = (r_state == ST_CHK) && !i_sts.done;
        // The result register may be refilled in the cycle its beat is taken.
        o_cmd.res_load = (r_state == ST_CHK) && i_sts.done && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (!i_sts.done) n_state = ST_MUL;
                else if (o_cmd.res_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.res_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before its beat was taken");

    a_load_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_MUL))
        else $error("accepted point did not start an iteration");

    a_step_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !i_sts.done && !o_cmd.res_load)
        else $error("iteration step issued after the point finished");

    a_result_flags_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> r_out_valid && (r_state == ST_IDLE))
        else $error("finished point did not raise an output beat");

endmodule

/* sv/mandelbrot_escape_time_unit.sv */
// Top level of the Mandelbrot escape-time unit: register port, controller and datapath.
//
// Usage: each input beat on s_axis carries one grid point (row, column) of a
// 1024 x 1024 grid mapped onto [-2,2)x[-2,2) in Q4.28. The unit iterates
// z = z^2 + c from zero and returns one output beat on m_axis with the count
// of iterations and a flag set when the count reached max_iter.
// Each iteration runs through ST_MUL, which registers the three 32 x 32 products,
// and then ST_CHK, which tests |z|^2 and updates z. A point that runs N
// iterations has its result registered from ST_CHK once it is done, and the unit
// takes the next point only back in ST_IDLE, so no new point is taken until the
// earlier one is finished; a point inside the set takes N = max_iter (10000 after reset).
// The result sits in an output register; if the receiver stalls, the unit still takes
// and iterates the next point and holds it finished until the earlier beat is taken.
// max_iter is written through the register port at byte address 0; the user must
// write it only while the unit is idle, which the block does not enforce. Reset
// empties the pipeline and sets max_iter to 10000.
module mandelbrot_escape_time_unit
    import met_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // [9:0] row_index, [19:10] col_index
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [15:0] iterations
    output logic [0:0]        m_axis_tuser    // [0] inside_res
);

    logic [ITER_W-1:0] r_max_iter;
    logic              w_sel_max_iter;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic              w_inside;
    logic [ITER_W-1:0] w_iter;

    assign pready         = 1'b1;
    assign w_sel_max_iter = (paddr[ADDR_W-1] == REG_MAX_ITER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
        end else if (psel && penable && pwrite && pready && w_sel_max_iter) begin
            r_max_iter <= pwdata[ITER_W-1:0];
        end
    end

    assign prdata = w_sel_max_iter ? {16'b0, r_max_iter} : 32'b0;

    met_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    met_dp u_dp (
        .i_clk        (i_clk),
        .i_row_index  (s_axis_tdata[IDX_W-1:0]),
        .i_col_index  (s_axis_tdata[2*IDX_W-1:IDX_W]),
        .i_max_iter   (r_max_iter),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_inside_res (w_inside),
        .o_iterations (w_iter)
    );

    assign m_axis_tdata = w_iter;
    assign m_axis_tuser = w_inside;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the Mandelbrot escape-time unit, with its own escape-count model.
module testbench
    import met_pkg::*;
();

    localparam int                IDLE_LIMIT    = 400000;
    localparam logic [ADDR_W-1:0] MAX_ITER_ADDR = ADDR_W'(int'(REG_MAX_ITER) * 4);

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_grid_point;

    typedef struct {
        logic              in_set;
        logic [ITER_W-1:0] iterations;
    } t_escape_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;   // [9:0] row_index, [19:10] col_index
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;        // [15:0] iterations
    logic [0:0]        m_axis_tuser;        // [0] inside_res

    t_grid_point       points_to_send[$];
    t_escape_result    expected_counts[$];
    logic [ITER_W-1:0] iter_limit = MAX_ITER_RST;
    int                mismatch_count = 0;
    int                send_gap = 0;
    int                send_burst = 0;
    int                take_stall = 0;
    int                take_burst = 0;
    int                idle_cycles = 0;

    mandelbrot_escape_time_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly no gap or a short one, now and then a long one; bursts run with no gap at all.
    function automatic int pick_gap(inout int burst);
        int roll;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            burst = $urandom_range(5, 20);
            return 0;
        end
        if (roll < 10) return 0;
        if (roll < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [63:0] grid_to_fixed(input logic [IDX_W-1:0] idx);
        logic signed [63:0] offset;
        offset = $signed({54'd0, idx}) - GRID / 2;
        return (offset * 4 * (64'sd1 <<< FRAC_BITS)) / GRID;
    endfunction

    function automatic logic signed [63:0] fixed_mul(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] prod;
        prod = a * b;
        return prod >>> FRAC_BITS;
    endfunction

    function automatic t_escape_result escape_count(input t_grid_point pt,
                                                    input logic [ITER_W-1:0] limit);
        logic signed [63:0] c_re;
        logic signed [63:0] c_im;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] xx;
        logic signed [63:0] yy;
        logic signed [63:0] x_next;
        logic signed [63:0] bound;
        int                 n;
        t_escape_result     res;
        c_re  = grid_to_fixed(pt.row);
        c_im  = grid_to_fixed(pt.col);
        bound = 64'sd4 <<< FRAC_BITS;
        x = 0;
        y = 0;
        n = 0;
        forever begin
            xx = fixed_mul(x, x);
            yy = fixed_mul(y, y);
            if (xx + yy > bound || n >= int'(limit)) break;
            x_next = xx - yy + c_re;
            y      = ((x * y * 2) >>> FRAC_BITS) + c_im;
            x      = x_next;
            n++;
        end
        res.in_set     = (n == int'(limit));
        res.iterations = n[ITER_W-1:0];
        return res;
    endfunction

    // Input side: the expectation is formed when the beat is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_counts.push_back(escape_count('{row: s_axis_tdata[9:0],
                                                         col: s_axis_tdata[19:10]},
                                                       iter_limit));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (points_to_send.size() > 0) begin
                    t_grid_point pt;
                    pt = points_to_send.pop_front();
                    s_axis_tdata  <= {4'd0, pt.col, pt.row};
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(send_burst);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: random back-pressure and in-order comparison.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_counts.size() == 0) begin
                    $error("unexpected result beat: iterations %0d, inside_res %0d",
                           m_axis_tdata, m_axis_tuser[0]);
                    mismatch_count++;
                end else begin
                    t_escape_result exp_res;
                    exp_res = expected_counts.pop_front();
                    if (m_axis_tuser[0] !== exp_res.in_set) begin
                        $error("inside_res: expected %0d, got %0d",
                               exp_res.in_set, m_axis_tuser[0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata !== exp_res.iterations) begin
                        $error("iterations: expected %0d, got %0d",
                               exp_res.iterations, m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (take_stall > 0) begin
                take_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                take_stall = pick_gap(take_burst);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_until_drained();
        while (points_to_send.size() != 0 || s_axis_tvalid || expected_counts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_iteration_limit(input logic [ITER_W-1:0] limit);
        logic [31:0] readback;
        wait_until_drained();
        apb_access(1'b1, MAX_ITER_ADDR, {16'd0, limit}, readback);
        iter_limit = limit;
        apb_access(1'b0, MAX_ITER_ADDR, '0, readback);
        if (readback[ITER_W-1:0] !== limit) begin
            $error("max_iter: expected %0d, got %0d", limit, readback[ITER_W-1:0]);
            mismatch_count++;
        end
    endtask

    task automatic queue_point(input int row, input int col);
        points_to_send.push_back('{row: row[IDX_W-1:0], col: col[IDX_W-1:0]});
    endtask

    // Most random points fall in the box around the set, where escape takes many steps.
    task automatic queue_random_points(input int count);
        repeat (count) begin
            if ($urandom_range(0, 9) < 6)
                queue_point($urandom_range(128, 640), $urandom_range(256, 768));
            else
                queue_point($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limit: grid corners and c = 1 escape; the origin, c = -1 and c = -i stay inside.
        queue_point(0, 0);
        queue_point(1023, 1023);
        queue_point(0, 1023);
        queue_point(1023, 0);
        queue_point(512, 512);
        queue_point(256, 512);
        queue_point(768, 512);
        queue_point(512, 256);

        // A zero limit runs no step and flags every point as inside.
        set_iteration_limit(16'd0);
        queue_point(512, 512);
        queue_point(0, 0);
        queue_point(1023, 1023);

        set_iteration_limit(16'd1);
        queue_point(512, 512);
        queue_point(0, 0);
        queue_point(1023, 1023);
        queue_point(341, 682);

        set_iteration_limit(16'hFFFF);
        queue_point(512, 512);
        queue_point(700, 300);
        queue_point(1023, 0);

        set_iteration_limit(ITER_W'($urandom_range(2, 64)));
        queue_random_points(50);

        set_iteration_limit(ITER_W'($urandom_range(100, 400)));
        queue_random_points(50);

        wait_until_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_counts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
